[src/trapezoid_pulse_waveform_macros.svh]
// Assertion macros for the trapezoid pulse waveform checker.
// Used by trapezoid_pulse_waveform_chk.sv only.
`ifndef TRAPEZOID_PULSE_WAVEFORM_MACROS_SVH
`define TRAPEZOID_PULSE_WAVEFORM_MACROS_SVH
// Property that must hold on every clock edge outside reset.
`define TPW_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Property that is checked even while reset is low.
`define TPW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

[src/tpw_pkg.sv]
// Package for the trapezoid pulse waveform block: widths, register indexes,
// and the record passed from front to back. No dependencies.
package tpw_pkg;
  localparam int unsigned TimeBits  = 32;
  localparam int unsigned LevelBits = 16;
  localparam int unsigned MagBits   = LevelBits;
  localparam int unsigned ProdBits  = TimeBits + MagBits;
  localparam int unsigned IdxBits   = 3;
  localparam int unsigned CfgBits   = 32;
  localparam int unsigned QDepth    = 4;
  localparam int unsigned QPtrBits  = 2;

  typedef enum logic [IdxBits-1:0] {
    RegLevelLow  = 3'd0,
    RegLevelHigh = 3'd1,
    RegDelay     = 3'd2,
    RegRise      = 3'd3,
    RegTop       = 3'd4,
    RegFall      = 3'd5,
    RegPeriod    = 3'd6,
    RegSpare     = 3'd7
  } reg_idx_e;

  // What the back end must do with an item.
  typedef enum logic [1:0] {
    KindLow  = 2'd0,
    KindHigh = 2'd1,
    KindRise = 2'd2,
    KindFall = 2'd3
  } kind_e;

  // Classified item: product numerator with its span, base level and sign.
  typedef struct packed {
    kind_e                 kind;
    logic [ProdBits-1:0]   prod;
    logic [TimeBits-1:0]   span;
    logic                  neg;
    logic [LevelBits-1:0]  low;
    logic [LevelBits-1:0]  high;
  } job_t;
endpackage

[src/trapezoid_pulse_waveform.sv]
// Trapezoid pulse waveform source, top level.
// Channels: s_axis (time_now in tdata[31:0]) and m_axis (level_out in
// tdata[15:0]), both tvalid/tready; an item moves when both are high.
// Config: cfg_we_i/cfg_idx_i/cfg_wdata_i, writes take effect at once.
// The user must make writes only while the block is idle; the block does
// not enforce this. Path from input accept to output valid: 1 delay stage,
// modulo pipeline, classify, multiply, 17-stage divide, queue.
// Throughput: one item per cycle while the pipeline is not frozen; the
// bit-serial modulo and divide pipelines take one bit per stage.
// The pipeline advances as one; a 4-entry output queue decouples it from
// the receiver. When the receiver stalls, the pipeline freezes while the
// item leaving it would find the queue full, so no item is lost.
// Reset: configuration registers to zero (output low level 0), pipeline
// and queue empty.
// Depends on tpw_pkg, tpw_front, tpw_back, tpw_queue.
module trapezoid_pulse_waveform (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,   // [31:0] time_now
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata,   // [15:0] level_out
  input  logic                          cfg_we_i,
  input  logic [tpw_pkg::IdxBits-1:0]   cfg_idx_i,
  input  logic [tpw_pkg::CfgBits-1:0]   cfg_wdata_i
);
  localparam int unsigned TB = tpw_pkg::TimeBits;
  localparam int unsigned LB = tpw_pkg::LevelBits;
  localparam int unsigned CW = tpw_pkg::QPtrBits + 1;

  // Configuration registers.
  logic [LB-1:0] low_q, high_q;
  logic [TB-1:0] delay_q, rise_q, top_q, fall_q, period_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q <= '0; high_q <= '0; delay_q <= '0; rise_q <= '0;
      top_q <= '0; fall_q <= '0; period_q <= '0;
    end else if (cfg_we_i) begin
      case (tpw_pkg::reg_idx_e'(cfg_idx_i))
        tpw_pkg::RegLevelLow:  low_q    <= cfg_wdata_i[LB-1:0];
        tpw_pkg::RegLevelHigh: high_q   <= cfg_wdata_i[LB-1:0];
        tpw_pkg::RegDelay:     delay_q  <= cfg_wdata_i[TB-1:0];
        tpw_pkg::RegRise:      rise_q   <= cfg_wdata_i[TB-1:0];
        tpw_pkg::RegTop:       top_q    <= cfg_wdata_i[TB-1:0];
        tpw_pkg::RegFall:      fall_q   <= cfg_wdata_i[TB-1:0];
        tpw_pkg::RegPeriod:    period_q <= cfg_wdata_i[TB-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline enable: advance unless the result leaving would find the
  // queue full.
  logic                      en, f_vld, b_vld, q_vld;
  tpw_pkg::job_t             job;
  logic [LB-1:0]             b_lvl;
  logic [tpw_pkg::QPtrBits:0] q_cnt;
  logic                      pop;
  assign pop = m_axis_tready && q_vld;
  assign en  = !(b_vld && (q_cnt == CW'(tpw_pkg::QDepth)) && !pop);
  assign s_axis_tready = en;

  tpw_front u_front (
    .clk_i, .rst_ni, .en_i(en),
    .vld_i(s_axis_tvalid), .time_i(s_axis_tdata[TB-1:0]),
    .low_i(low_q), .high_i(high_q), .delay_i(delay_q), .rise_i(rise_q),
    .top_i(top_q), .fall_i(fall_q), .period_i(period_q),
    .vld_o(f_vld), .job_o(job)
  );

  tpw_back u_back (
    .clk_i, .rst_ni, .en_i(en), .vld_i(f_vld), .job_i(job),
    .vld_o(b_vld), .level_o(b_lvl)
  );

  tpw_queue u_queue (
    .clk_i, .rst_ni, .push_i(b_vld && en), .data_i(b_lvl), .pop_i(pop),
    .valid_o(q_vld), .data_o(m_axis_tdata), .count_o(q_cnt)
  );
  assign m_axis_tvalid = q_vld;
endmodule

[src/tpw_mod.sv]
// Pipelined unsigned modulo: phase = x % period, one bit per stage.
// Depends on tpw_pkg.
module tpw_mod (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          vld_i,
  input  logic [tpw_pkg::TimeBits-1:0]  x_i,
  input  logic [tpw_pkg::TimeBits-1:0]  per_i,
  input  logic                          lowf_i,
  output logic                          vld_o,
  output logic [tpw_pkg::TimeBits-1:0]  rem_o,
  output logic                          lowf_o
);
  localparam int unsigned N = tpw_pkg::TimeBits;
  logic [N:0]   vld_q;
  logic [N:0]   lowf_q;
  logic [N-1:0] rem_q [N+1];
  logic [N-1:0] x_q   [N+1];
  logic [N-1:0] per_q [N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[N-1:0], vld_i};
    end
  end

  // Stage k brings in bit N-1-k of x into the partial remainder.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= '0;
      x_q[0]    <= x_i;
      per_q[0]  <= per_i;
      lowf_q[0] <= lowf_i;
      for (int k = 0; k < N; k++) begin
        logic [N:0] r;
        r = {rem_q[k], x_q[k][N-1-k]};
        if (r >= {1'b0, per_q[k]}) r = r - {1'b0, per_q[k]};
        rem_q[k+1]  <= r[N-1:0];
        x_q[k+1]    <= x_q[k];
        per_q[k+1]  <= per_q[k];
        lowf_q[k+1] <= lowf_q[k];
      end
    end
  end

  assign vld_o  = vld_q[N];
  assign rem_o  = rem_q[N];
  assign lowf_o = lowf_q[N];
endmodule

[src/tpw_front.sv]
// Front end: delay check, phase by pipelined modulo, segment classify and
// ramp product. Depends on tpw_pkg and tpw_mod.
module tpw_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           vld_i,
  input  logic [tpw_pkg::TimeBits-1:0]   time_i,
  input  logic [tpw_pkg::LevelBits-1:0]  low_i,
  input  logic [tpw_pkg::LevelBits-1:0]  high_i,
  input  logic [tpw_pkg::TimeBits-1:0]   delay_i,
  input  logic [tpw_pkg::TimeBits-1:0]   rise_i,
  input  logic [tpw_pkg::TimeBits-1:0]   top_i,
  input  logic [tpw_pkg::TimeBits-1:0]   fall_i,
  input  logic [tpw_pkg::TimeBits-1:0]   period_i,
  output logic                           vld_o,
  output tpw_pkg::job_t                  job_o
);
  localparam int unsigned TB = tpw_pkg::TimeBits;
  localparam int unsigned LB = tpw_pkg::LevelBits;

  // Stage 0: subtract delay, flag the constant-low cases.
  logic          s0_vld_q, s0_low_q;
  logic [TB-1:0] s0_x_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s0_vld_q <= 1'b0;
    else if (en_i) s0_vld_q <= vld_i;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s0_x_q   <= time_i - delay_i;
      s0_low_q <= (time_i <= delay_i) || (period_i == '0);
    end
  end

  logic          m_vld, m_low;
  logic [TB-1:0] m_ph;
  tpw_mod u_mod (
    .clk_i, .rst_ni, .en_i,
    .vld_i(s0_vld_q), .x_i(s0_x_q),
    .per_i((period_i == '0) ? {{(TB-1){1'b0}}, 1'b1} : period_i),
    .lowf_i(s0_low_q), .vld_o(m_vld), .rem_o(m_ph), .lowf_o(m_low)
  );

  // Stage 1: classify the phase into a segment.
  logic          s1_vld_q;
  tpw_pkg::kind_e s1_kind_q;
  logic [TB-1:0] s1_off_q, s1_span_q;
  logic [LB:0]   s1_diff_q;
  logic [TB-1:0] past_rise, into_fall;
  tpw_pkg::kind_e kind_d;
  logic [TB-1:0] off_d, span_d;
  always_comb begin
    past_rise = m_ph - rise_i;
    into_fall = past_rise - top_i;
    off_d  = m_ph;
    span_d = rise_i;
    if (m_low) kind_d = tpw_pkg::KindLow;
    else if (rise_i != '0 && m_ph < rise_i) kind_d = tpw_pkg::KindRise;
    else if (past_rise <= top_i) kind_d = tpw_pkg::KindHigh;
    else if (fall_i != '0 && into_fall < fall_i) begin
      kind_d = tpw_pkg::KindFall;
      off_d  = into_fall;
      span_d = fall_i;
    end else kind_d = tpw_pkg::KindLow;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_vld_q <= 1'b0;
    else if (en_i) s1_vld_q <= m_vld;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_kind_q <= kind_d;
      s1_off_q  <= off_d;
      s1_span_q <= span_d;
      s1_diff_q <= {high_i[LB-1], high_i} - {low_i[LB-1], low_i};
    end
  end

  // Stage 2: magnitude times offset.
  logic [LB-1:0] mag;
  logic [LB:0]   ndiff;
  always_comb begin
    ndiff = -s1_diff_q;
    mag   = s1_diff_q[LB] ? ndiff[LB-1:0] : s1_diff_q[LB-1:0];
  end
  logic          s2_vld_q;
  tpw_pkg::job_t s2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_vld_q <= 1'b0;
    else if (en_i) s2_vld_q <= s1_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_q.kind <= s1_kind_q;
      s2_q.prod <= {{LB{1'b0}}, s1_off_q} * {{TB{1'b0}}, mag};
      s2_q.span <= s1_span_q;
      s2_q.neg  <= s1_diff_q[LB];
      s2_q.low  <= low_i;
      s2_q.high <= high_i;
    end
  end
  assign vld_o = s2_vld_q;
  assign job_o = s2_q;
endmodule

[src/tpw_back.sv]
// Back end: pipelined restoring divide of the ramp product and level build.
// Depends on tpw_pkg.
module tpw_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           vld_i,
  input  tpw_pkg::job_t                  job_i,
  output logic                           vld_o,
  output logic [tpw_pkg::LevelBits-1:0]  level_o
);
  localparam int unsigned TB = tpw_pkg::TimeBits;
  localparam int unsigned LB = tpw_pkg::LevelBits;
  localparam int unsigned PB = tpw_pkg::ProdBits;

  // Quotient is below the magnitude, so LB steps suffice after
  // the high part of the product is reduced (high part < span).
  logic [LB:0]   vld_q;
  tpw_pkg::job_t job_q [LB+1];
  logic [TB:0]   rem_q [LB+1];
  logic [LB-1:0] quo_q [LB+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en_i) vld_q <= {vld_q[LB-1:0], vld_i};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      job_q[0] <= job_i;
      rem_q[0] <= {1'b0, job_i.prod[PB-1:LB]};
      quo_q[0] <= '0;
      for (int k = 0; k < LB; k++) begin
        logic [TB+1:0] r;
        r = {rem_q[k], job_q[k].prod[LB-1-k]};
        job_q[k+1] <= job_q[k];
        if (job_q[k].kind == tpw_pkg::KindRise || job_q[k].kind == tpw_pkg::KindFall) begin
          if (r >= {2'b00, job_q[k].span}) begin
            r = r - {2'b00, job_q[k].span};
            quo_q[k+1] <= {quo_q[k][LB-2:0], 1'b1};
          end else quo_q[k+1] <= {quo_q[k][LB-2:0], 1'b0};
        end else quo_q[k+1] <= '0;
        rem_q[k+1] <= r[TB:0];
      end
    end
  end

  // Final level from the quotient.
  logic [LB-1:0] q, part;
  tpw_pkg::job_t j;
  always_comb begin
    j    = job_q[LB];
    q    = quo_q[LB];
    part = j.neg ? -q : q;
    case (j.kind)
      tpw_pkg::KindHigh: level_o = j.high;
      tpw_pkg::KindRise: level_o = j.low + part;
      tpw_pkg::KindFall: level_o = j.high - part;
      default:           level_o = j.low;
    endcase
  end
  assign vld_o = vld_q[LB];
endmodule

[src/tpw_queue.sv]
// Output queue that parts the pipeline from the receiver; depth QDepth.
// Depends on tpw_pkg.
module tpw_queue (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic [tpw_pkg::LevelBits-1:0]  data_i,
  input  logic                           pop_i,
  output logic                           valid_o,
  output logic [tpw_pkg::LevelBits-1:0]  data_o,
  output logic [tpw_pkg::QPtrBits:0]     count_o
);
  localparam int unsigned PW = tpw_pkg::QPtrBits;
  logic [tpw_pkg::LevelBits-1:0] mem_q [tpw_pkg::QDepth];
  logic [PW-1:0] wr_q, rd_q;
  logic [PW:0]   cnt_q;
  logic          do_pop;
  assign do_pop = pop_i && (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + {{PW{1'b0}}, push_i} - {{PW{1'b0}}, do_pop};
    end
  end
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];
  assign count_o = cnt_q;
endmodule

[src/trapezoid_pulse_waveform_chk.sv]
// Port-level checker for the trapezoid pulse waveform, bound to the top.
// Depends on trapezoid_pulse_waveform_macros.svh.
`include "trapezoid_pulse_waveform_macros.svh"
module trapezoid_pulse_waveform_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);
  // Output stays offered until taken.
  `TPW_ASSERT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "valid dropped")
  // Stalled data holds.
  `TPW_ASSERT(a_data, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "data moved")
  // Input is never refused while output is being drained freely.
  `TPW_ASSERT(a_ready, clk_i, rst_ni, m_axis_tready |-> s_axis_tready, "input stalled with free output")
  // No output shortly after reset.
  `TPW_ASSERT_ALWAYS(a_rst, clk_i, !rst_ni |=> !m_axis_tvalid, "output after reset")
endmodule

bind trapezoid_pulse_waveform trapezoid_pulse_waveform_chk u_chk (.*);

[dv/tb_trapezoid_pulse_waveform.sv]
// Testbench for the trapezoid pulse waveform source: directed table plus
// random time values, checked against fixed or in-bench predicted levels.
// Depends on tpw_pkg and trapezoid_pulse_waveform.
module tb_trapezoid_pulse_waveform;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LatencyCycles = 60;
  localparam int unsigned CycleLimit    = 400000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        cfg_we_i;
  logic [tpw_pkg::IdxBits-1:0] cfg_idx_i;
  logic [tpw_pkg::CfgBits-1:0] cfg_wdata_i;

  trapezoid_pulse_waveform dut (.*);

  // Predictor copy of the registers
  logic signed [15:0] lvl_lo, lvl_hi;
  logic [31:0] dly, rise, top, fall, per;

  logic [15:0] level_queue[$];
  int unsigned mismatches;
  int unsigned levels_seen;
  int unsigned cycles;
  bit          hold_off;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("timeout after %0d cycles", cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Signed ramp step, truncated toward zero
  function automatic logic signed [31:0] ramp_step(logic signed [31:0] diff,
                                                   logic [31:0] off, logic [31:0] span);
    logic [63:0] mag;
    logic [63:0] q;
    mag = diff < 0 ? 64'(-diff) : 64'(diff);
    q = (mag * 64'(off)) / 64'(span);
    return diff < 0 ? -32'(q) : 32'(q);
  endfunction

  function automatic logic [15:0] pulse_level(logic [31:0] t);
    logic signed [31:0] diff, lv;
    logic [31:0] ph, past, into;
    diff = 32'(lvl_hi) - 32'(lvl_lo);
    if (t <= dly || per == 0) lv = 32'(lvl_lo);
    else begin
      ph = (t - dly) % per;
      if (rise != 0 && ph < rise) lv = 32'(lvl_lo) + ramp_step(diff, ph, rise);
      else begin
        past = ph - rise;
        if (past <= top) lv = 32'(lvl_hi);
        else begin
          into = past - top;
          if (fall != 0 && into < fall) lv = 32'(lvl_hi) - ramp_step(diff, into, fall);
          else lv = 32'(lvl_lo);
        end
      end
    end
    return lv[15:0];
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    mismatches++;
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
  endtask

  // Receiver with its own stall pattern and a long hold-off
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off) m_axis_tready <= 1'b0;
      else m_axis_tready <= ($urandom_range(0, 9) < 7) || (cycles % 512 < 60);
    end
  end

  // Compare each accepted level with the oldest expectation
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        levels_seen++;
        if (level_queue.size() == 0) report_mismatch("unexpected", m_axis_tdata, 16'h0);
        else begin
          logic [15:0] want;
          want = level_queue.pop_front();
          if (m_axis_tdata !== want) report_mismatch("level_out", m_axis_tdata, want);
        end
      end
    end
  end

  // One register write; the caller drops the write enable after the last one
  task automatic write_reg(tpw_pkg::reg_idx_e idx, logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      tpw_pkg::RegLevelLow:  lvl_lo = val[15:0];
      tpw_pkg::RegLevelHigh: lvl_hi = val[15:0];
      tpw_pkg::RegDelay:     dly = val;
      tpw_pkg::RegRise:      rise = val;
      tpw_pkg::RegTop:       top = val;
      tpw_pkg::RegFall:      fall = val;
      tpw_pkg::RegPeriod:    per = val;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (level_queue.size() != 0) @(posedge clk_i);
    repeat (LatencyCycles) @(posedge clk_i);
  endtask

  task automatic set_shape(logic [31:0] lo, logic [31:0] hi, logic [31:0] d,
                           logic [31:0] r, logic [31:0] tp, logic [31:0] f,
                           logic [31:0] p);
    wait_drained();
    write_reg(tpw_pkg::RegLevelLow, lo);
    write_reg(tpw_pkg::RegLevelHigh, hi);
    write_reg(tpw_pkg::RegDelay, d);
    write_reg(tpw_pkg::RegRise, r);
    write_reg(tpw_pkg::RegTop, tp);
    write_reg(tpw_pkg::RegFall, f);
    write_reg(tpw_pkg::RegPeriod, p);
    write_reg(tpw_pkg::RegSpare, $urandom());
    cfg_we_i <= 1'b0;
  endtask

  // Offer one item; expectation queued when accepted. Optional fixed result.
  task automatic send_time(logic [31:0] t, bit fixed, logic [15:0] want);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= t;
    do @(posedge clk_i); while (!s_axis_tready);
    level_queue.push_back(fixed ? want : pulse_level(t));
  endtask

  task automatic idle_gap();
    s_axis_tvalid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  typedef struct {
    logic [31:0] t;
    bit          fixed;
    logic [15:0] want;
  } stim_row_t;

  stim_row_t dir_rows[20];
  int unsigned sent;

  // Random burst of times around the pulse shape
  task automatic random_burst(int unsigned n);
    logic [31:0] t;
    int unsigned k;
    k = 0;
    while (k < n) begin
      case ($urandom_range(0, 3))
        0: t = $urandom();
        1: t = dly + $urandom_range(0, 3);
        default: t = dly + (per == 0 ? $urandom_range(0, 200)
                                     : $urandom_range(0, 3) * per + $urandom() % per);
      endcase
      send_time(t, 1'b0, 16'h0);
      k++;
      sent++;
      if ($urandom_range(0, 7) == 0) idle_gap();
    end
    s_axis_tvalid <= 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = tpw_pkg::RegLevelLow;
    cfg_wdata_i = '0;
    hold_off = 1'b0;
    mismatches = 0;
    levels_seen = 0;
    sent = 0;
    {lvl_lo, lvl_hi} = '0;
    {dly, rise, top, fall, per} = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // After reset everything is zero: output low level 0
    dir_rows[0] = '{32'h0, 1'b1, 16'h0};
    dir_rows[1] = '{32'hFFFF_FFFF, 1'b1, 16'h0};
    foreach (dir_rows[i]) if (i < 2) send_time(dir_rows[i].t, dir_rows[i].fixed, dir_rows[i].want);
    s_axis_tvalid <= 1'b0;

    // Extremes of the level, ramps of 10, period 40
    set_shape(32'hFFFF_8000, 32'h0000_7FFF, 5, 10, 5, 10, 40);
    dir_rows[0]  = '{32'd5, 1'b1, 16'h8000};   // at the delay: low
    dir_rows[1]  = '{32'd10, 1'b1, 16'hFFFF};  // phase 5 of 10: low + 32767
    dir_rows[2]  = '{32'd15, 1'b1, 16'h7FFF};  // top start
    dir_rows[3]  = '{32'd20, 1'b1, 16'h7FFF};  // top end
    dir_rows[4]  = '{32'd21, 1'b0, 16'h0};
    dir_rows[5]  = '{32'd30, 1'b1, 16'h8000};  // fall done
    dir_rows[6]  = '{32'd45, 1'b1, 16'h8000};  // wrap to phase 0
    dir_rows[7]  = '{32'd6, 1'b0, 16'h0};
    dir_rows[8]  = '{32'd14, 1'b0, 16'h0};
    dir_rows[9]  = '{32'd29, 1'b0, 16'h0};
    dir_rows[10] = '{32'hFFFF_FFFF, 1'b0, 16'h0};
    for (int i = 0; i < 11; i++) send_time(dir_rows[i].t, dir_rows[i].fixed, dir_rows[i].want);
    s_axis_tvalid <= 1'b0;
    // Zero ramps, high below low, short period cutting the shape
    set_shape(32'h0000_7FFF, 32'hFFFF_8000, 0, 0, 3, 0, 6);
    for (int i = 0; i < 8; i++) send_time(i, 1'b0, 16'h0);
    s_axis_tvalid <= 1'b0;
    set_shape(100, 32'hFFFF_FF00, 0, 7, 2, 9, 10);
    for (int i = 0; i < 12; i++) send_time(i, 1'b0, 16'h0);
    s_axis_tvalid <= 1'b0;
    // Zero period: constant low
    set_shape(32'h1234, 32'h4321, 0, 3, 3, 3, 0);
    send_time(32'h8000_0000, 1'b1, 16'h1234);
    s_axis_tvalid <= 1'b0;

    // Random phases, several settings including huge times
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7)
        set_shape($urandom(), $urandom(), 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF);
      else if (ph == 6)
        set_shape($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                  $urandom(), $urandom());
      else
        set_shape($urandom(), $urandom(), $urandom_range(0, 50), $urandom_range(0, 40),
                  $urandom_range(0, 40), $urandom_range(0, 40), $urandom_range(0, 150));
      if (ph == 2) begin
        // Long receiver hold-off so the block fills and stalls input
        hold_off = 1'b1;
        fork
          begin repeat (300) @(posedge clk_i); hold_off = 1'b0; end
          random_burst(80);
        join
      end else random_burst(80);
      if (ph == 4) while (level_queue.size() != 0) @(posedge clk_i);
    end

    wait_drained();
    $display("covered %0d random and directed times over 13 register settings", sent + 34);
    $display("%0d levels checked, %0d mismatches", levels_seen, mismatches);
    if (mismatches == 0 && level_queue.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
